// ----- hdl/crtp_pkg.sv -----
// shared types, constants and control structs of the convolution row tile planner
package crtp_pkg;

  // row counts are capped at this value
  localparam int MAX_ROWS = 4096;

  // field and datapath widths
  localparam int ROW_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 21;              // row times stride
  localparam int END_W    = PROD_W + 1;      // signed input row positions
  localparam int TOT_W    = ROW_W + 1;       // junk plus useful rows
  localparam int DIV_W    = PROD_W;          // divider dividend width
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // configuration port
  localparam int NUM_REGS = 7;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
  localparam int DATA_W   = 32;

  localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(MAX_ROWS);
  localparam logic [ROW_W-1:0] ROW_SAT = '1;

  // register indexes on the configuration port
  typedef enum logic [ADDR_W-3:0] {
    REG_PAD_TOP,
    REG_PAD_BOT,
    REG_ROW_STRIDE,
    REG_KERNEL_ROWS,
    REG_IN_ROWS,
    REG_OUT_ROWS,
    REG_TILE_LIMIT
  } reg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_FIRST,
    ST_END,
    ST_BL_GO,
    ST_BL_WAIT,
    ST_JPRE_GO,
    ST_JPRE_WAIT,
    ST_JPOST_GO,
    ST_JPOST_WAIT,
    ST_CHECK,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // dividend source of the shared divider
  typedef enum logic [1:0] {
    DIV_BL,
    DIV_JPRE,
    DIV_JPOST
  } div_sel_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [BYTE_W-1:0] pad_top;
    logic [BYTE_W-1:0] pad_bot;
    logic [BYTE_W-1:0] row_stride;
    logic [BYTE_W-1:0] kernel_rows;
    logic [ROW_W-1:0]  in_rows;
    logic [ROW_W-1:0]  out_rows;
    logic [ROW_W-1:0]  tile_limit;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     restart;
    logic     span;
    logic     first_load;
    logic     end_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_bl;
    logic     cap_jpre;
    logic     cap_jpost;
    logic     shrink;
    logic     load_tile;
    logic     load_empty;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic span_empty;
    logic first_neg;
    logic div_done;
    logic over;
    logic last;
  } sts_t;

  // one tile descriptor
  typedef struct packed {
    logic              tile_valid;
    logic [ROW_W-1:0]  in_lines_done;
    logic [ROW_W-1:0]  out_lines_done;
    logic [ROW_W-1:0]  junk_rows_before;
    logic [BYTE_W-1:0] junk_rows_after;
    logic [ROW_W-1:0]  first_in_row;
    logic [ROW_W-1:0]  end_in_row;
    logic [ROW_W-1:0]  first_out_row;
    logic [ROW_W-1:0]  end_out_row;
    logic              last_tile;
  } rsp_t;

endpackage

// ----- hdl/crtp_if.sv -----
// request and tile descriptor channel interfaces

interface crtp_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface crtp_rsp_if import crtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tile_valid;
  logic [ROW_W-1:0]  in_lines_done;
  logic [ROW_W-1:0]  out_lines_done;
  logic [ROW_W-1:0]  junk_rows_before;
  logic [BYTE_W-1:0] junk_rows_after;
  logic [ROW_W-1:0]  first_in_row;
  logic [ROW_W-1:0]  end_in_row;
  logic [ROW_W-1:0]  first_out_row;
  logic [ROW_W-1:0]  end_out_row;
  logic              last_tile;

  modport source (
    output valid, input ready,
    output tile_valid, output in_lines_done, output out_lines_done,
    output junk_rows_before, output junk_rows_after, output first_in_row,
    output end_in_row, output first_out_row, output end_out_row, output last_tile
  );
  modport sink (
    input valid, output ready,
    input tile_valid, input in_lines_done, input out_lines_done,
    input junk_rows_before, input junk_rows_after, input first_in_row,
    input end_in_row, input first_out_row, input end_out_row, input last_tile
  );
endinterface

// ----- hdl/crtp_cfg_regs.sv -----
// configuration register file with its apb write and read port
module crtp_cfg_regs import crtp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [BYTE_W-1:0] pad_top;
  logic [BYTE_W-1:0] pad_bot;
  logic [BYTE_W-1:0] row_stride;
  logic [BYTE_W-1:0] kernel_rows;
  logic [ROW_W-1:0]  in_rows;
  logic [ROW_W-1:0]  out_rows;
  logic [ROW_W-1:0]  tile_limit;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_top     <= '0;
      pad_bot     <= '0;
      row_stride  <= BYTE_W'(1);
      kernel_rows <= BYTE_W'(1);
      in_rows     <= ROW_W'(1);
      out_rows    <= ROW_W'(1);
      tile_limit  <= '0;
    end else if (wr) begin
      case (idx)
        REG_PAD_TOP:     pad_top     <= pwdata[BYTE_W-1:0];
        REG_PAD_BOT:     pad_bot     <= pwdata[BYTE_W-1:0];
        REG_ROW_STRIDE:  row_stride  <= pwdata[BYTE_W-1:0];
        REG_KERNEL_ROWS: kernel_rows <= pwdata[BYTE_W-1:0];
        REG_IN_ROWS:     in_rows     <= pwdata[ROW_W-1:0];
        REG_OUT_ROWS:    out_rows    <= pwdata[ROW_W-1:0];
        REG_TILE_LIMIT:  tile_limit  <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_PAD_TOP:     prdata = DATA_W'(pad_top);
      REG_PAD_BOT:     prdata = DATA_W'(pad_bot);
      REG_ROW_STRIDE:  prdata = DATA_W'(row_stride);
      REG_KERNEL_ROWS: prdata = DATA_W'(kernel_rows);
      REG_IN_ROWS:     prdata = DATA_W'(in_rows);
      REG_OUT_ROWS:    prdata = DATA_W'(out_rows);
      REG_TILE_LIMIT:  prdata = DATA_W'(tile_limit);
      default:         prdata = '0;
    endcase
  end

  // effective values: zero stride acts as one, row counts capped
  always_comb begin
    cfg.pad_top     = pad_top;
    cfg.pad_bot     = pad_bot;
    cfg.row_stride  = (row_stride == '0) ? BYTE_W'(1) : row_stride;
    cfg.kernel_rows = kernel_rows;
    cfg.in_rows     = (in_rows > ROW_CAP) ? ROW_CAP : in_rows;
    cfg.out_rows    = (out_rows > ROW_CAP) ? ROW_CAP : out_rows;
    cfg.tile_limit  = (tile_limit > ROW_CAP) ? ROW_CAP : tile_limit;
  end

endmodule

// ----- hdl/crtp_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module crtp_div import crtp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [BYTE_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quo,
  output logic [BYTE_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [BYTE_W-1:0]    dvs;
  logic [BYTE_W:0]      partial;
  logic                 fits;

  // trial subtraction of one step
  assign partial = {rem, quo[DIV_W-1]};
  assign fits    = partial >= {1'b0, dvs};

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? BYTE_W'(partial - {1'b0, dvs}) : partial[BYTE_W-1:0];
    end
  end

endmodule

// ----- hdl/crtp_datapath.sv -----
// tile geometry datapath: row registers, multiplier, shared divider, result register
module crtp_datapath import crtp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t result
);

  logic [ROW_W-1:0]  s;
  logic [ROW_W-1:0]  e;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] first;
  logic              first_neg;
  logic [BYTE_W-1:0] bl;
  logic [ROW_W-1:0]  jpre;
  logic [BYTE_W-1:0] jpost;
  logic signed [END_W-1:0] end_row;

  logic [ROW_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [ROW_W:0]    span_sum;
  logic [ROW_W-1:0]  e_span;

  logic signed [END_W-1:0] first_raw;
  logic signed [END_W-1:0] end_init;
  logic signed [END_W-1:0] st_x;
  logic signed [END_W-1:0] pt_x;
  logic signed [END_W-1:0] pb_x;
  logic signed [END_W-1:0] kr_x;
  logic signed [END_W-1:0] ir_x;
  logic signed [END_W-1:0] used;
  logic signed [END_W-1:0] end_c;
  logic                    end_gt;
  logic                    jp_ok;
  logic [BYTE_W-1:0]       jp_num;

  logic [TOT_W-1:0]  total;
  logic [END_W:0]    inl;
  logic [PROD_W-1:0] fir;

  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [BYTE_W-1:0] div_rem;

  // sign-safe copies of the configuration
  assign st_x = $signed({{(END_W-BYTE_W){1'b0}}, cfg.row_stride});
  assign pt_x = $signed({{(END_W-BYTE_W){1'b0}}, cfg.pad_top});
  assign pb_x = $signed({{(END_W-BYTE_W){1'b0}}, cfg.pad_bot});
  assign kr_x = $signed({{(END_W-BYTE_W){1'b0}}, cfg.kernel_rows});
  assign ir_x = $signed({{(END_W-ROW_W){1'b0}}, cfg.in_rows});

  // row times stride, registered
  assign mul_a = cmd.span ? s : e;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(cfg.row_stride);

  // initial tile end: tile_limit rows, not past out_rows
  assign span_sum = {1'b0, s} + {1'b0, cfg.tile_limit};
  assign e_span   = (span_sum > {1'b0, cfg.out_rows}) ? cfg.out_rows : span_sum[ROW_W-1:0];

  // first and last input rows before clamping
  assign first_raw = $signed({1'b0, prod}) - pt_x;
  assign end_init  = $signed({1'b0, prod}) - st_x + kr_x - pt_x;

  // bottom padding used by the tile and its junk rows after
  assign end_gt = end_row > ir_x;
  assign used   = end_row - ir_x;
  assign jp_ok  = !end_gt || (used <= pb_x);
  assign jp_num = end_gt ? (cfg.pad_bot - used[BYTE_W-1:0]) : cfg.pad_bot;
  assign end_c  = end_gt ? ir_x : end_row;

  // output lines of the tile, junk included
  assign total = TOT_W'(jpre) + TOT_W'(e - s) + TOT_W'(jpost);

  // descriptor values before saturation
  assign inl = {end_c[END_W-1], end_c} + {{(END_W+1-BYTE_W){1'b0}}, bl}
             - {2'b00, first};
  assign fir = first - PROD_W'(bl);

  // dividend select
  always_comb begin
    case (cmd.div_sel)
      DIV_BL:    div_dividend = first;
      DIV_JPRE:  div_dividend = DIV_W'(bl) + DIV_W'(cfg.pad_top);
      DIV_JPOST: div_dividend = DIV_W'(jp_num);
      default:   div_dividend = '0;
    endcase
  end

  crtp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (cfg.row_stride),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // plan position
  always_ff @(posedge clk) begin
    if (rst) begin
      s <= '0;
    end else if (cmd.restart) begin
      s <= '0;
    end else if (cmd.load_tile) begin
      s <= e;
    end
  end

  // tile geometry registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.span) begin
      e <= e_span;
    end else if (cmd.shrink) begin
      e <= e - ROW_W'(1);
    end
    if (cmd.first_load) begin
      first_neg <= first_raw[END_W-1];
      if (first_raw[END_W-1]) begin
        first <= '0;
        bl    <= '0;
        jpre  <= s;
      end else begin
        first <= first_raw[PROD_W-1:0];
      end
    end
    if (cmd.cap_bl) begin
      bl <= div_rem;
    end
    if (cmd.cap_jpre) begin
      jpre <= div_quo[ROW_W-1:0];
    end
    if (cmd.end_load) begin
      end_row <= end_init;
    end else if (cmd.shrink) begin
      end_row <= end_row - st_x;
    end
    if (cmd.cap_jpost) begin
      jpost <= jp_ok ? div_quo[BYTE_W-1:0] : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_empty) begin
      result <= '0;
    end else if (cmd.load_tile) begin
      result.tile_valid       <= 1'b1;
      result.in_lines_done    <= inl[END_W] ? '0 :
                                 (|inl[END_W-1:ROW_W]) ? ROW_SAT : inl[ROW_W-1:0];
      result.out_lines_done   <= total[TOT_W-1] ? ROW_SAT : total[ROW_W-1:0];
      result.junk_rows_before <= jpre;
      result.junk_rows_after  <= jpost;
      result.first_in_row     <= (|fir[PROD_W-1:ROW_W]) ? ROW_SAT : fir[ROW_W-1:0];
      result.end_in_row       <= end_c[END_W-1] ? '0 : end_c[ROW_W-1:0];
      result.first_out_row    <= s;
      result.end_out_row      <= e;
      result.last_tile        <= sts.last;
    end
  end

  // status to the controller
  always_comb begin
    sts.span_empty = e <= s;
    sts.first_neg  = first_neg;
    sts.div_done   = div_done;
    sts.over       = (total > TOT_W'(cfg.tile_limit)) && (e > s);
    sts.last       = (e == s) || (e >= cfg.out_rows);
  end

endmodule

// ----- hdl/crtp_ctrl.sv -----
// sequencing state machine of the tile planner
module crtp_ctrl import crtp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_restart,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   plan_done;
  logic   out_valid;
  logic   accept;
  logic   out_free;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid & req_ready;
  assign out_free  = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (plan_done && !req_restart) ? ST_FINISH : ST_SPAN;
        end
      end
      ST_SPAN:     state_next = ST_FIRST;
      ST_FIRST:    state_next = sts.span_empty ? ST_FINISH : ST_END;
      ST_END:      state_next = sts.first_neg ? ST_JPOST_GO : ST_BL_GO;
      ST_BL_GO:    state_next = ST_BL_WAIT;
      ST_BL_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_JPRE_GO;
        end
      end
      ST_JPRE_GO:  state_next = ST_JPRE_WAIT;
      ST_JPRE_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_JPOST_GO;
        end
      end
      ST_JPOST_GO: state_next = ST_JPOST_WAIT;
      ST_JPOST_WAIT: begin
        if (sts.div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK:    state_next = sts.over ? ST_JPOST_GO : ST_WRITE;
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_BL;
    cmd.restart = accept & req_restart;
    case (state)
      ST_SPAN:       cmd.span = 1'b1;
      ST_FIRST:      cmd.first_load = 1'b1;
      ST_END:        cmd.end_load = 1'b1;
      ST_BL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BL;
      end
      ST_BL_WAIT:    cmd.cap_bl = sts.div_done;
      ST_JPRE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_JPRE;
      end
      ST_JPRE_WAIT:  cmd.cap_jpre = sts.div_done;
      ST_JPOST_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_JPOST;
      end
      ST_JPOST_WAIT: cmd.cap_jpost = sts.div_done;
      ST_CHECK:      cmd.shrink = sts.over;
      ST_WRITE:      cmd.load_tile = out_free;
      ST_FINISH:     cmd.load_empty = out_free;
      default: ;
    endcase
  end

  // state, plan status and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plan_done <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.restart) begin
        plan_done <= 1'b0;
      end else if (cmd.load_empty || (cmd.load_tile && sts.last)) begin
        plan_done <= 1'b1;
      end
      if (cmd.load_tile || cmd.load_empty) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/conv_row_tile_planner.sv -----
// convolution row tile planner: one tile descriptor per request item
// per item: span, first row, end row, then three divisions on the shared 21-step divider
//   (bl, junk before, junk after) and one more junk-after division per row the end is
//   pulled back; the first two are skipped when the tile starts in top padding
// a finished plan or an empty span answers with an empty descriptor; one item at a time
// reset: registers to defaults, plan finished, next output row 0, no result pending
module conv_row_tile_planner import crtp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  crtp_req_if.sink          req,
  crtp_rsp_if.source        rsp
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  rsp_t result;

  crtp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crtp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_restart (req.restart),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  crtp_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  // descriptor fields onto the result channel
  assign rsp.tile_valid       = result.tile_valid;
  assign rsp.in_lines_done    = result.in_lines_done;
  assign rsp.out_lines_done   = result.out_lines_done;
  assign rsp.junk_rows_before = result.junk_rows_before;
  assign rsp.junk_rows_after  = result.junk_rows_after;
  assign rsp.first_in_row     = result.first_in_row;
  assign rsp.end_in_row       = result.end_in_row;
  assign rsp.first_out_row    = result.first_out_row;
  assign rsp.end_out_row      = result.end_out_row;
  assign rsp.last_tile        = result.last_tile;

endmodule
